@@ rtl/core/dijet_deltaphi_event_selector_assert.svh @@
// Assertion macros shared by the checker of the dijet delta-phi event selector.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef DIJET_DELTAPHI_EVENT_SELECTOR_ASSERT_SVH
`define DIJET_DELTAPHI_EVENT_SELECTOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DDES_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dijet selector assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define DDES_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dijet selector assertion failed");

`endif

@@ rtl/core/ddes_pkg.sv @@
// ----------------------------------------------------------------------------
// ddes_pkg
// Types, constants and the arctangent table of the dijet delta-phi selector.
// ----------------------------------------------------------------------------
package ddes_pkg;

	localparam int NUM_BINS_DEF     = 50;
	localparam int COUNT_WIDTH_DEF  = 32;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_ENTRIES     = 24;

	// CORDIC datapath width: a 16-bit component scaled by 2^16 plus gain headroom.
	localparam int CW = 36;

	localparam int IN_W  = 176;
	localparam int OUT_W = 56;
	localparam int REG_W = 15;
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_JET_MASS_LIMIT   = 3'd0;
	localparam logic [IDX_W-1:0] REG_TARGET_MASS      = 3'd1;
	localparam logic [IDX_W-1:0] REG_MASS_HALF_WINDOW = 3'd2;
	localparam logic [IDX_W-1:0] REG_MET_LOW          = 3'd3;
	localparam logic [IDX_W-1:0] REG_MET_HIGH         = 3'd4;

	localparam logic [REG_W-1:0] RST_JET_MASS_LIMIT   = 15'd3840;
	localparam logic [REG_W-1:0] RST_TARGET_MASS      = 15'd8000;
	localparam logic [REG_W-1:0] RST_MASS_HALF_WINDOW = 15'd1920;
	localparam logic [REG_W-1:0] RST_MET_LOW          = 15'd640;
	localparam logic [REG_W-1:0] RST_MET_HIGH         = 15'd9600;

	localparam logic [1:0] ST_SELECTED = 2'd0;
	localparam logic [1:0] ST_JET_MASS = 2'd1;
	localparam logic [1:0] ST_DIJET    = 2'd2;
	localparam logic [1:0] ST_MET      = 2'd3;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [31:0]          z;
	} cordic_t;

	// atan(2^-i) on a 2^32 full-turn scale.
	function automatic logic [31:0] atan_angle(input int idx);
		logic [31:0] a;
		case (idx)
			0:  a = 32'h20000000;
			1:  a = 32'h12E4051E;
			2:  a = 32'h09FB385B;
			3:  a = 32'h051111D4;
			4:  a = 32'h028B0D43;
			5:  a = 32'h0145D7E1;
			6:  a = 32'h00A2F61E;
			7:  a = 32'h00517C55;
			8:  a = 32'h0028BE53;
			9:  a = 32'h00145F2F;
			10: a = 32'h000A2F98;
			11: a = 32'h000517CC;
			12: a = 32'h00028BE6;
			13: a = 32'h000145F3;
			14: a = 32'h0000A2F9;
			15: a = 32'h0000517D;
			16: a = 32'h000028BE;
			17: a = 32'h0000145F;
			18: a = 32'h00000A30;
			19: a = 32'h00000518;
			20: a = 32'h0000028C;
			21: a = 32'h00000146;
			22: a = 32'h000000A3;
			23: a = 32'h00000051;
			default: a = 32'h0;
		endcase
		return a;
	endfunction

endpackage

@@ rtl/core/ddes_ram.sv @@
// ----------------------------------------------------------------------------
// ddes_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ddes_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 50
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ rtl/core/ddes_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// ddes_cordic_cell
// One vectoring CORDIC iteration with its output register.
// ----------------------------------------------------------------------------
module ddes_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic             clk,
	input  logic             en,
	input  ddes_pkg::cordic_t d_in,
	output ddes_pkg::cordic_t d_out
);
	import ddes_pkg::*;

	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;
	cordic_t              nxt;

	always_comb begin
		dx = d_in.y >>> STEP;
		dy = d_in.x >>> STEP;
		if (!d_in.y[CW-1]) begin
			nxt.x = d_in.x + dx;
			nxt.y = d_in.y - dy;
			nxt.z = d_in.z + atan_angle(STEP);
		end else begin
			nxt.x = d_in.x - dx;
			nxt.y = d_in.y + dy;
			nxt.z = d_in.z - atan_angle(STEP);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end
endmodule

@@ rtl/core/dijet_deltaphi_event_selector.sv @@
// ----------------------------------------------------------------------------
// dijet_deltaphi_event_selector
// Dijet mass and missing-energy event selection with a delta-phi histogram.
// ----------------------------------------------------------------------------
// Events arrive as words on the s_ channel (s_tvalid, s_tready, s_tdata) and
// one result word per event leaves on the m_ channel; m_tuser carries the
// status code. Thresholds are written through wr_en, wr_index and wr_data;
// the user must write them only while no event is in flight; the block does
// not enforce it. Throughput is one event per cycle unless the receiver
// stalls. Latency from acceptance to m_tvalid is set by the chain of CORDIC
// cells, one iteration per cell, followed by the histogram read-modify-write.
// The histogram lives in a RAM with registered read; a counter written in the
// previous cycle is forwarded so events that hit one bin back to back count
// correctly. Per-bin valid flops, cleared at reset, make every bin read as
// zero until it is first written, so no clearing pass is needed.
// Reset clears the pipeline, the valid flops and restores the thresholds.
// When the receiver stalls, the whole pipeline holds and s_tready drops; it
// rises again as soon as the waiting result word is taken.
// ----------------------------------------------------------------------------
module dijet_deltaphi_event_selector #(
	parameter int NUM_BINS     = ddes_pkg::NUM_BINS_DEF,
	parameter int COUNT_WIDTH  = ddes_pkg::COUNT_WIDTH_DEF,
	parameter int CORDIC_STEPS = ddes_pkg::CORDIC_STEPS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// Fields from bit 0 up: jet0_px, jet0_py, jet0_pz, jet0_energy, jet0_mass,
	// jet1_px, jet1_py, jet1_pz, jet1_energy, jet1_mass, missing_energy, zero fill.
	input  logic [ddes_pkg::IN_W-1:0]   s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// Fields from bit 0 up: delta_phi, hist_bin, bin_count, zero fill.
	output logic [ddes_pkg::OUT_W-1:0]  m_tdata,
	// Fields from bit 0 up: status.
	output logic [1:0]                  m_tuser,
	input  logic                        wr_en,
	input  logic [ddes_pkg::IDX_W-1:0]  wr_index,
	input  logic [ddes_pkg::REG_W-1:0]  wr_data
);
	import ddes_pkg::*;

	localparam int BIN_W = $clog2(NUM_BINS);
	// Stage numbers: 1 input register, 2 CORDIC start, S_CD CORDIC done.
	localparam int S_CD = CORDIC_STEPS + 2;
	localparam int S_PH = S_CD + 1;
	localparam int S_RD = S_CD + 2;

	// Configuration registers.
	logic [REG_W-1:0] jet_mass_limit_q, target_mass_q, mass_half_window_q;
	logic [REG_W-1:0] met_low_q, met_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jet_mass_limit_q   <= RST_JET_MASS_LIMIT;
			target_mass_q      <= RST_TARGET_MASS;
			mass_half_window_q <= RST_MASS_HALF_WINDOW;
			met_low_q          <= RST_MET_LOW;
			met_high_q         <= RST_MET_HIGH;
		end else if (wr_en) begin
			case (wr_index)
				REG_JET_MASS_LIMIT:   jet_mass_limit_q   <= wr_data;
				REG_TARGET_MASS:      target_mass_q      <= wr_data;
				REG_MASS_HALF_WINDOW: mass_half_window_q <= wr_data;
				REG_MET_LOW:          met_low_q          <= wr_data;
				REG_MET_HIGH:         met_high_q         <= wr_data;
				default: ;
			endcase
		end
	end

	// The whole pipeline advances unless the result word is stalled.
	logic en;
	logic out_vld_q;
	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;

	logic vld_sk [1:S_RD];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= S_RD; k++) begin
				vld_sk[k] <= 1'b0;
			end
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_sk[1] <= s_tvalid;
			for (int k = 2; k <= S_RD; k++) begin
				vld_sk[k] <= vld_sk[k-1];
			end
			out_vld_q <= vld_sk[S_RD];
		end
	end

	// Stage 1: input register.
	logic signed [15:0] px0_s1, py0_s1, pz0_s1, px1_s1, py1_s1, pz1_s1;
	logic [14:0]        e0_s1, m0_s1, e1_s1, m1_s1, met_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			px0_s1 <= s_tdata[15:0];
			py0_s1 <= s_tdata[31:16];
			pz0_s1 <= s_tdata[47:32];
			e0_s1  <= s_tdata[62:48];
			m0_s1  <= s_tdata[77:63];
			px1_s1 <= s_tdata[93:78];
			py1_s1 <= s_tdata[109:94];
			pz1_s1 <= s_tdata[125:110];
			e1_s1  <= s_tdata[140:126];
			m1_s1  <= s_tdata[155:141];
			met_s1 <= s_tdata[170:156];
		end
	end

	// Stage 2: four-momentum sums and the simple cuts.
	logic [15:0]        e_s2;
	logic signed [16:0] sx_s2, sy_s2, sz_s2;
	logic               jm_fail_s2, met_fail_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			e_s2        <= 16'(e0_s1) + 16'(e1_s1);
			sx_s2       <= 17'(px0_s1) + 17'(px1_s1);
			sy_s2       <= 17'(py0_s1) + 17'(py1_s1);
			sz_s2       <= 17'(pz0_s1) + 17'(pz1_s1);
			jm_fail_s2  <= !(m0_s1 < jet_mass_limit_q && m1_s1 < jet_mass_limit_q);
			met_fail_s2 <= !(met_s1 >= met_low_q && met_s1 <= met_high_q);
		end
	end

	// Stage 3: squares and the squared window bounds.
	logic [31:0]        esq_s3, hisq_s3, losq_s3;
	logic [32:0]        sxsq_s3, sysq_s3, szsq_s3;
	logic               lo_neg_s3, jm_fail_s3, met_fail_s3;
	logic [15:0]        hi_c;
	logic signed [16:0] lo_c;
	logic signed [33:0] sxsq_c, sysq_c, szsq_c, losq_c;

	always_comb begin
		hi_c   = 16'(target_mass_q) + 16'(mass_half_window_q);
		lo_c   = $signed(17'(target_mass_q)) - $signed(17'(mass_half_window_q));
		sxsq_c = sx_s2 * sx_s2;
		sysq_c = sy_s2 * sy_s2;
		szsq_c = sz_s2 * sz_s2;
		losq_c = lo_c * lo_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			esq_s3      <= e_s2 * e_s2;
			sxsq_s3     <= sxsq_c[32:0];
			sysq_s3     <= sysq_c[32:0];
			szsq_s3     <= szsq_c[32:0];
			hisq_s3     <= hi_c * hi_c;
			losq_s3     <= losq_c[31:0];
			lo_neg_s3   <= lo_c[16];
			jm_fail_s3  <= jm_fail_s2;
			met_fail_s3 <= met_fail_s2;
		end
	end

	// Stage 4: invariant mass window and the status code, then a delay line
	// that meets the CORDIC results.
	logic [35:0] m2_c;
	logic        mass_ok_c;
	logic [1:0]  status_c;
	logic [1:0]  stat_sk [4:S_CD];

	always_comb begin
		m2_c = 36'(esq_s3) - 36'(sxsq_s3) - 36'(sysq_s3) - 36'(szsq_s3);
		mass_ok_c = !m2_c[35] && (mass_half_window_q != '0)
			&& (m2_c[34:0] < 35'(hisq_s3))
			&& (lo_neg_s3 || (m2_c[34:0] > 35'(losq_s3)));
		if (jm_fail_s3) begin
			status_c = ST_JET_MASS;
		end else if (!mass_ok_c) begin
			status_c = ST_DIJET;
		end else if (met_fail_s3) begin
			status_c = ST_MET;
		end else begin
			status_c = ST_SELECTED;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stat_sk[4] <= status_c;
			for (int k = 5; k <= S_CD; k++) begin
				stat_sk[k] <= stat_sk[k-1];
			end
		end
	end

	// CORDIC: pre-rotation of left half plane vectors into the right half plane, then the cells.
	cordic_t      cord0 [0:CORDIC_STEPS];
	cordic_t      cord1 [0:CORDIC_STEPS];
	cordic_t      pre0_c, pre1_c;
	logic [1:0]   zero_sk [2:S_CD];

	function automatic cordic_t pre_rotate(input logic signed [15:0] px,
		input logic signed [15:0] py);
		cordic_t r;
		r.x = {{(CW-32){px[15]}}, px, 16'b0};
		r.y = {{(CW-32){py[15]}}, py, 16'b0};
		r.z = 32'h0;
		if (px[15]) begin
			r.x = -r.x;
			r.y = -r.y;
			r.z = 32'h80000000;
		end
		return r;
	endfunction

	always_comb begin
		pre0_c = pre_rotate(px0_s1, py0_s1);
		pre1_c = pre_rotate(px1_s1, py1_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cord0[0]   <= pre0_c;
			cord1[0]   <= pre1_c;
			zero_sk[2] <= {(px1_s1 == '0) && (py1_s1 == '0),
				(px0_s1 == '0) && (py0_s1 == '0)};
			for (int k = 3; k <= S_CD; k++) begin
				zero_sk[k] <= zero_sk[k-1];
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		ddes_cordic_cell #(.STEP(i)) u_cell0 (
			.clk(clk), .en(en), .d_in(cord0[i]), .d_out(cord0[i+1])
		);
		ddes_cordic_cell #(.STEP(i)) u_cell1 (
			.clk(clk), .en(en), .d_in(cord1[i]), .d_out(cord1[i+1])
		);
	end

	// Stage S_CD: round both angles to 16 bits and take the difference.
	logic [31:0] zr0_c, zr1_c;
	logic [15:0] phi0_c, phi1_c;
	logic [15:0] dphi_st1;
	logic [1:0]  status_st1;

	always_comb begin
		zr0_c  = cord0[CORDIC_STEPS].z + 32'h00008000;
		zr1_c  = cord1[CORDIC_STEPS].z + 32'h00008000;
		phi0_c = zero_sk[S_CD][0] ? 16'h0 : zr0_c[31:16];
		phi1_c = zero_sk[S_CD][1] ? 16'h0 : zr1_c[31:16];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dphi_st1   <= phi0_c - phi1_c;
			status_st1 <= stat_sk[S_CD];
		end
	end

	// Stage S_PH: bin selection and histogram read.
	logic [31:0]            bin_prod_c;
	logic [BIN_W-1:0]       bin_c;
	logic [BIN_W-1:0]       bin_st2;
	logic [15:0]            dphi_st2;
	logic [1:0]             status_st2;
	logic                   bvalid_st2;
	logic [NUM_BINS-1:0]    bin_valid_q;

	always_comb begin
		bin_prod_c = 32'(dphi_st1 ^ 16'h8000) * 32'(NUM_BINS);
		bin_c      = bin_prod_c[16 +: BIN_W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bin_st2    <= bin_c;
			dphi_st2   <= dphi_st1;
			status_st2 <= status_st1;
			bvalid_st2 <= bin_valid_q[bin_c];
		end
	end

	// Stage S_RD: count update with forwarding of the previous write.
	logic [COUNT_WIDTH-1:0] ram_rdata;
	logic [COUNT_WIDTH-1:0] base_c, cnt_c;
	logic                   wr_c, hit_c;
	logic                   fwd_vld_q;
	logic [BIN_W-1:0]       fwd_bin_q;
	logic [COUNT_WIDTH-1:0] fwd_cnt_q;
	logic [63:0]            cnt64_c;

	ddes_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_BINS)) u_hist (
		.clk(clk), .we(wr_c), .waddr(bin_st2), .wdata(cnt_c),
		.re(en), .raddr(bin_c), .rdata(ram_rdata)
	);

	always_comb begin
		hit_c  = fwd_vld_q && (fwd_bin_q == bin_st2);
		base_c = hit_c ? fwd_cnt_q : (bvalid_st2 ? ram_rdata : '0);
		cnt_c  = (&base_c) ? base_c : base_c + 1'b1;
		wr_c   = en && vld_sk[S_RD] && (status_st2 == ST_SELECTED);
		cnt64_c = 64'(cnt_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_valid_q <= '0;
			fwd_vld_q   <= 1'b0;
		end else if (en) begin
			fwd_vld_q <= wr_c;
			if (wr_c) begin
				bin_valid_q[bin_st2] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_c) begin
			fwd_bin_q <= bin_st2;
			fwd_cnt_q <= cnt_c;
		end
	end

	// Output register.
	logic [1:0]  out_status_q;
	logic [15:0] out_dphi_q;
	logic [5:0]  out_bin_q;
	logic [31:0] out_cnt_q;
	logic [15:0] bin16_c;

	assign bin16_c = 16'(bin_st2);

	always_ff @(posedge clk) begin
		if (en) begin
			out_status_q <= status_st2;
			if (status_st2 == ST_SELECTED) begin
				out_dphi_q <= dphi_st2;
				out_bin_q  <= bin16_c[5:0];
				out_cnt_q  <= cnt64_c[31:0];
			end else begin
				out_dphi_q <= '0;
				out_bin_q  <= '0;
				out_cnt_q  <= '0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {2'b00, out_cnt_q, out_bin_q, out_dphi_q};
endmodule

@@ rtl/core/ddes_checker.sv @@
// ----------------------------------------------------------------------------
// ddes_checker
// Port-level checks of the dijet delta-phi event selector.
// ----------------------------------------------------------------------------
`include "dijet_deltaphi_event_selector_assert.svh"

module ddes_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [ddes_pkg::OUT_W-1:0] m_tdata,
	input logic [1:0]                 m_tuser
);
	import ddes_pkg::*;

	// A stalled result word keeps its contents.
	`DDES_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// A rejected event reports zero angle, bin and count.
	`DDES_ASSERT_NOW(a_reject_zero, m_tvalid && (m_tuser != ST_SELECTED), m_tdata[53:0] == '0)

	// A selected event has just incremented a saturating counter.
	`DDES_ASSERT_NOW(a_count_nonzero, m_tvalid && (m_tuser == ST_SELECTED), m_tdata[53:22] != '0)
endmodule

bind dijet_deltaphi_event_selector ddes_checker u_ddes_checker (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tuser(m_tuser)
);
